/* rtl/sit_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared constants and types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Default coordinate width, two's complement.
  localparam int COORD_WIDTH_DEF = 16;

  // Point-on-segment tests: one per endpoint of the two segments.
  localparam int NUM_TESTS = 4;

  // Sign information of one orientation test.
  typedef struct packed {
    logic cr_zero;  // cross product is zero
    logic cr_pos;   // cross product is strictly positive
    logic dt_pos;   // dot product is strictly positive
  } sit_flags_t;

endpackage : sit_pkg
`default_nettype wire

/* rtl/sit_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection channels
// Valid/ready channels carrying a segment pair in and a hit flag out.
// ----------------------------------------------------------------------------
interface sit_in_if #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_start_x;
  logic signed [COORD_WIDTH-1:0] first_start_y;
  logic signed [COORD_WIDTH-1:0] first_end_x;
  logic signed [COORD_WIDTH-1:0] first_end_y;
  logic signed [COORD_WIDTH-1:0] second_start_x;
  logic signed [COORD_WIDTH-1:0] second_start_y;
  logic signed [COORD_WIDTH-1:0] second_end_x;
  logic signed [COORD_WIDTH-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
    output second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
    input  second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface : sit_in_if

interface sit_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface : sit_out_if
`default_nettype wire

/* rtl/segment_intersection_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection test
// Four-stage pipeline that reports whether two line segments touch or cross.
// ----------------------------------------------------------------------------
// Each word on the input channel holds two segments given by four signed
// integer points; each word on the output channel holds one hit bit, 1 when
// the segments share at least one point. The test is exact: an endpoint that
// lies on the other segment counts as a hit, and otherwise the segments hit
// when each one's endpoints fall strictly on different sides of the other's
// line. The block accepts one word every clock cycle unless backpressure
// stalls it. Its result is registered through the pipeline: endpoint
// differences, the sixteen products, the cross and dot signs, and the final
// decision each take one stage. Backpressure on the output stalls only the
// stages that are full, so empty stages keep taking new words.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sit_in_if.sink     in_seg,
  sit_out_if.source  out_seg
);
  import sit_pkg::*;

  // A difference of two coordinates needs one more bit, a product of two
  // differences twice that, and a sum of two products one more again.
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DW-1:0]          diff_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic signed [SW-1:0]          sum_t;

  // Handshake along the pipeline. A stage can load when it is empty or
  // when the stage after it is moving on.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_seg.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_seg.ready = rdy1;

  assign v1_nxt = rdy1 ? in_seg.valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Every test looks at a point P against a segment AB. The cross product of
  // (A - P) and (B - P) equals the orientation of A, B, P, so the same value
  // serves both the on-segment test and the strict-left test.
  //   test 0: second start against the first segment
  //   test 1: second end against the first segment
  //   test 2: first start against the second segment
  //   test 3: first end against the second segment
  coord_t ax [NUM_TESTS];
  coord_t ay [NUM_TESTS];
  coord_t bx [NUM_TESTS];
  coord_t by [NUM_TESTS];
  coord_t px [NUM_TESTS];
  coord_t py [NUM_TESTS];

  always_comb begin
    ax[0] = in_seg.first_start_x;   ay[0] = in_seg.first_start_y;
    bx[0] = in_seg.first_end_x;     by[0] = in_seg.first_end_y;
    px[0] = in_seg.second_start_x;  py[0] = in_seg.second_start_y;

    ax[1] = in_seg.first_start_x;   ay[1] = in_seg.first_start_y;
    bx[1] = in_seg.first_end_x;     by[1] = in_seg.first_end_y;
    px[1] = in_seg.second_end_x;    py[1] = in_seg.second_end_y;

    ax[2] = in_seg.second_start_x;  ay[2] = in_seg.second_start_y;
    bx[2] = in_seg.second_end_x;    by[2] = in_seg.second_end_y;
    px[2] = in_seg.first_start_x;   py[2] = in_seg.first_start_y;

    ax[3] = in_seg.second_start_x;  ay[3] = in_seg.second_start_y;
    bx[3] = in_seg.second_end_x;    by[3] = in_seg.second_end_y;
    px[3] = in_seg.first_end_x;     py[3] = in_seg.first_end_y;
  end

  // Stage 1: vectors from the test point to both endpoints.
  diff_t ux_r [NUM_TESTS];
  diff_t uy_r [NUM_TESTS];
  diff_t vx_r [NUM_TESTS];
  diff_t vy_r [NUM_TESTS];
  diff_t ux_nxt [NUM_TESTS];
  diff_t uy_nxt [NUM_TESTS];
  diff_t vx_nxt [NUM_TESTS];
  diff_t vy_nxt [NUM_TESTS];

  always_comb begin
    for (int k = 0; k < NUM_TESTS; k++) begin
      ux_nxt[k] = {ax[k][COORD_WIDTH-1], ax[k]} - {px[k][COORD_WIDTH-1], px[k]};
      uy_nxt[k] = {ay[k][COORD_WIDTH-1], ay[k]} - {py[k][COORD_WIDTH-1], py[k]};
      vx_nxt[k] = {bx[k][COORD_WIDTH-1], bx[k]} - {px[k][COORD_WIDTH-1], px[k]};
      vy_nxt[k] = {by[k][COORD_WIDTH-1], by[k]} - {py[k][COORD_WIDTH-1], py[k]};
    end
  end

  // Stage 2: the four products of each test, one multiplier apiece.
  prod_t cra_r [NUM_TESTS];
  prod_t crb_r [NUM_TESTS];
  prod_t dta_r [NUM_TESTS];
  prod_t dtb_r [NUM_TESTS];
  prod_t cra_nxt [NUM_TESTS];
  prod_t crb_nxt [NUM_TESTS];
  prod_t dta_nxt [NUM_TESTS];
  prod_t dtb_nxt [NUM_TESTS];

  always_comb begin
    for (int k = 0; k < NUM_TESTS; k++) begin
      cra_nxt[k] = prod_t'(ux_r[k]) * prod_t'(vy_r[k]);
      crb_nxt[k] = prod_t'(uy_r[k]) * prod_t'(vx_r[k]);
      dta_nxt[k] = prod_t'(ux_r[k]) * prod_t'(vx_r[k]);
      dtb_nxt[k] = prod_t'(uy_r[k]) * prod_t'(vy_r[k]);
    end
  end

  // Stage 3: cross and dot products reduced to their signs.
  sit_flags_t flags_r [NUM_TESTS];
  sit_flags_t flags_nxt [NUM_TESTS];
  sum_t       cr [NUM_TESTS];
  sum_t       dt [NUM_TESTS];

  always_comb begin
    for (int k = 0; k < NUM_TESTS; k++) begin
      cr[k] = {cra_r[k][PW-1], cra_r[k]} - {crb_r[k][PW-1], crb_r[k]};
      dt[k] = {dta_r[k][PW-1], dta_r[k]} + {dtb_r[k][PW-1], dtb_r[k]};
      flags_nxt[k].cr_zero = (cr[k] == '0);
      flags_nxt[k].cr_pos  = !cr[k][SW-1] && (cr[k] != '0);
      flags_nxt[k].dt_pos  = !dt[k][SW-1] && (dt[k] != '0);
    end
  end

  // Stage 4: the decision. A point lies on a segment when the cross product
  // is zero and the two vectors do not point the same way; an equal
  // endpoint gives a zero dot product and is covered by the same rule.
  logic hit_r;
  logic hit_nxt;
  logic on_any;
  logic cross_first;
  logic cross_second;

  always_comb begin
    on_any = 1'b0;
    for (int k = 0; k < NUM_TESTS; k++) begin
      on_any = on_any || (flags_r[k].cr_zero && !flags_r[k].dt_pos);
    end
    cross_first  = flags_r[0].cr_pos != flags_r[1].cr_pos;
    cross_second = flags_r[2].cr_pos != flags_r[3].cr_pos;
    hit_nxt      = on_any || (cross_first && cross_second);
  end

  // Data registers load only when their stage takes a valid word.
  always_ff @(posedge clk) begin
    if (rdy1 && in_seg.valid) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
    if (rdy2 && v1_r) begin
      cra_r <= cra_nxt;
      crb_r <= crb_nxt;
      dta_r <= dta_nxt;
      dtb_r <= dtb_nxt;
    end
    if (rdy3 && v2_r) begin
      flags_r <= flags_nxt;
    end
    if (rdy4 && v3_r) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_seg.valid = v4_r;
  assign out_seg.hit   = hit_r;

endmodule : segment_intersection_test
`default_nettype wire

/* rtl/sit_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection checker
// Port-level assertions on the segment intersection pipeline.
// ----------------------------------------------------------------------------
module sit_checker #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic signed [COORD_WIDTH-1:0] first_start_x,
  input wire logic signed [COORD_WIDTH-1:0] first_start_y,
  input wire logic signed [COORD_WIDTH-1:0] second_start_x,
  input wire logic signed [COORD_WIDTH-1:0] second_start_y,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_hit
);

  logic in_acc;
  logic shared_start;

  assign in_acc       = in_valid && in_ready;
  assign shared_start = (first_start_x == second_start_x) &&
                        (first_start_y == second_start_y);

  // Nothing is left in the pipeline after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  // With the output draining, a word comes out after four stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result word missing after pipeline latency");

  // Segments that start at the same point always hit.
  a_shared_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && shared_start) ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid && out_hit)
    else $error("segments sharing a start point reported as no hit");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("stalled result word changed");

endmodule : sit_checker

bind segment_intersection_test sit_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_sit_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_seg.valid),
  .in_ready       (in_seg.ready),
  .first_start_x  (in_seg.first_start_x),
  .first_start_y  (in_seg.first_start_y),
  .second_start_x (in_seg.second_start_x),
  .second_start_y (in_seg.second_start_y),
  .out_valid      (out_seg.valid),
  .out_ready      (out_seg.ready),
  .out_hit        (out_seg.hit)
);
`default_nettype wire
